// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check on every clock edge outside reset.
`define PFVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define PFVC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/pfvc_pkg.sv
// ----------------------------------------------------------------------------
// pfvc_pkg
// Widths, angle constants, register addresses and helper functions of the
// person-follow velocity controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pfvc_pkg;

    localparam int AHEAD_W  = 16;
    localparam int HEAD_W   = 13;
    localparam int ANG_W    = 14;
    localparam int ERR_W    = 16;
    localparam int SPEED_W  = 13;
    localparam int NUM_W    = 27;
    localparam int DEN_W    = 14;
    localparam int XY_W     = 32;
    localparam int Z_W      = 24;
    localparam int STEP_W   = 5;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [ANG_W:0] PI_MR     = 15'sd3142;
    localparam logic signed [ANG_W:0] TWO_PI_MR = 15'sd6283;
    localparam logic signed [ANG_W-1:0] QUAD_90 = 14'sd1571;
    localparam logic signed [ANG_W-1:0] QUAD_LO = 14'sd785;
    localparam logic signed [ANG_W-1:0] QUAD_HI = 14'sd2356;
    localparam logic [ERR_W-1:0] SLOW_ERR  = 16'd524;
    localparam logic [ERR_W-1:0] DEADBAND  = 16'd10;
    localparam logic signed [AHEAD_W-1:0] MIN_AHEAD = 16'sd10;
    localparam logic [12:0] DIV10_MUL = 13'd6554;

    localparam logic [ADDR_W-1:0] ADDR_MAX_FWD  = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_CORRIDOR = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_NEAR     = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_FAR      = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_TURN     = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_STALE    = 5'd20;

    function automatic logic signed [ANG_W-1:0] wrap_pi(input logic signed [ANG_W:0] a);
        logic signed [ANG_W:0] r;
        begin
            if (a > PI_MR)
                r = a - TWO_PI_MR;
            else if (a <= -PI_MR)
                r = a + TWO_PI_MR;
            else
                r = a;
            return r[ANG_W-1:0];
        end
    endfunction

    function automatic logic signed [ANG_W-1:0] round_quad(input logic signed [ANG_W-1:0] h);
        logic signed [ANG_W-1:0] r;
        begin
            if (h >= -QUAD_LO && h <= QUAD_LO)
                r = '0;
            else if (h > QUAD_LO && h <= QUAD_HI)
                r = QUAD_90;
            else if (h >= -QUAD_HI && h < -QUAD_LO)
                r = -QUAD_90;
            else
                r = PI_MR[ANG_W-1:0];
            return r;
        end
    endfunction

    // atan(2^-i) in units of 2^-20 radian
    function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] r;
        begin
            case (i)
                5'd0:    r = 24'd823550;
                5'd1:    r = 24'd486170;
                5'd2:    r = 24'd256879;
                5'd3:    r = 24'd130396;
                5'd4:    r = 24'd65451;
                5'd5:    r = 24'd32757;
                5'd6:    r = 24'd16383;
                5'd7:    r = 24'd8192;
                5'd8:    r = 24'd4096;
                5'd9:    r = 24'd2048;
                5'd10:   r = 24'd1024;
                5'd11:   r = 24'd512;
                5'd12:   r = 24'd256;
                5'd13:   r = 24'd128;
                5'd14:   r = 24'd64;
                5'd15:   r = 24'd32;
                5'd16:   r = 24'd16;
                5'd17:   r = 24'd8;
                5'd18:   r = 24'd4;
                5'd19:   r = 24'd2;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pfvc_div.sv
// ----------------------------------------------------------------------------
// pfvc_div
// Restoring divider, one quotient bit per cycle, for the forward ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pfvc_pkg::NUM_W-1:0]    num,
    input  wire logic [pfvc_pkg::DEN_W-1:0]    den,
    output logic                               busy,
    output logic [pfvc_pkg::NUM_W-1:0]         quo
);
    import pfvc_pkg::*;

    logic               run_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= STEP_W'(NUM_W - 1);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
                run_reg <= 1'b0;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
        end
    end

    assign busy = run_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfvc_cordic.sv
// ----------------------------------------------------------------------------
// pfvc_cordic
// Iterative vectoring CORDIC, one rotation per cycle, giving atan2 in mrad.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvc_cordic #(
    parameter int STEPS = 14
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [pfvc_pkg::AHEAD_W-1:0]  ahead,
    input  wire logic signed [pfvc_pkg::AHEAD_W-1:0]  side,
    output logic                                      busy,
    output logic signed [pfvc_pkg::ANG_W-1:0]         angle
);
    import pfvc_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic                     run_reg;
    logic                     fin_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [XY_W-1:0]   x_reg;
    logic signed [XY_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [ANG_W-1:0]  angle_reg;
    logic signed [XY_W-1:0]   xs;
    logic signed [XY_W-1:0]   ys;
    logic signed [Z_W-1:0]    at;
    logic [Z_W-1:0]           mag;
    logic [33:0]              prod;
    logic [ANG_W-1:0]         rnd;

    always_comb
    begin
        xs   = x_reg >>> step_reg;
        ys   = y_reg >>> step_reg;
        at   = signed'(atan_entry(step_reg));
        mag  = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);
        prod = 34'(mag) * 34'd1000 + 34'd524288;
        rnd  = prod[20 +: ANG_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            if (step_reg == LAST_STEP)
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
            step_reg <= step_reg + 1'b1;
        end
        else
        begin
            fin_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= {{(XY_W - AHEAD_W - 12){ahead[AHEAD_W-1]}}, ahead, 12'd0};
            y_reg <= {{(XY_W - AHEAD_W - 12){side[AHEAD_W-1]}}, side, 12'd0};
            z_reg <= '0;
        end
        else if (run_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
        if (fin_reg)
            angle_reg <= z_reg[Z_W-1] ? -signed'(rnd) : signed'(rnd);
    end

    assign busy  = run_reg | fin_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// File: rtl/core/person_follow_velocity_controller.sv
// ----------------------------------------------------------------------------
// person_follow_velocity_controller
// Turns a tracked person's position into forward and turn speed commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick: enable,
//   person position, sighting age, pose flag and robot heading.
//   Output channel (out_valid/out_stall) returns forward_speed and
//   turn_speed for that tick, exactly one request per tick.
//   The user writes registers through the APB port while the block is
//   idle; the block itself does not enforce this. A disabled, stale or
//   reversing tick goes from ST_EVAL to ST_DONE. A steering tick waits in
//   ST_WAIT for the 27-bit ramp divider, one quotient bit a cycle, and the
//   CORDIC unit, one rotation a cycle, then passes ST_STEER and ST_CLAMP to
//   ST_DONE. One tick is in work at a time; in_stall is high from acceptance
//   until the result is moved to the output register.
// Reset:
//   Registers return to their defaults, the held heading and heading error
//   clear, and both channels go idle.
// Stall:
//   A waiting result holds on the outputs; a new tick is still accepted and
//   its result holds in the core until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module person_follow_velocity_controller #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [pfvc_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [pfvc_pkg::DATA_W-1:0]           pwdata,
    output logic [pfvc_pkg::DATA_W-1:0]                prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  enabled,
    input  wire logic signed [pfvc_pkg::AHEAD_W-1:0]   target_ahead,
    input  wire logic signed [pfvc_pkg::AHEAD_W-1:0]   target_side,
    input  wire logic [7:0]                            sighting_age,
    input  wire logic                                  pose_valid,
    input  wire logic signed [pfvc_pkg::HEAD_W-1:0]    robot_heading,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [pfvc_pkg::SPEED_W-1:0]        forward_speed,
    output logic signed [pfvc_pkg::SPEED_W-1:0]        turn_speed
);
    import pfvc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_STEER = 6'b001000,
        ST_CLAMP = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg;

    logic [11:0] mx_reg;
    logic        corr_reg;
    logic [12:0] nr_reg;
    logic [13:0] fr_reg;
    logic [11:0] tl_reg;
    logic [7:0]  stale_reg;

    logic                      en_reg;
    logic signed [AHEAD_W-1:0] ahead_reg;
    logic signed [AHEAD_W-1:0] side_reg;
    logic [7:0]                age_reg;
    logic                      pv_reg;
    logic signed [ANG_W-1:0]   hd_reg;

    logic signed [ERR_W-1:0]   herr_reg;
    logic signed [ANG_W-1:0]   held_reg;
    logic                      held_valid_reg;
    logic                      band_reg;
    logic [11:0]               step_reg;
    logic signed [SPEED_W-1:0] fwd_reg;
    logic signed [SPEED_W-1:0] turn_reg;
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] out_fwd_reg;
    logic signed [SPEED_W-1:0] out_turn_reg;

    logic                      cfg_wr;
    logic signed [ANG_W-1:0]   hd_wrapped;
    logic signed [17:0]        ahead18;
    logic signed [17:0]        nr18;
    logic signed [17:0]        fr18;
    logic                      stop;
    logic                      band;
    logic                      rev;
    logic [17:0]               diff;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic [24:0]               tl_prod;
    logic                      div_start;
    logic                      cor_start;
    logic                      div_busy;
    logic                      cor_busy;
    logic [NUM_W-1:0]          quo;
    logic signed [ANG_W-1:0]   cor_angle;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   step_s;
    logic [ERR_W-1:0]          mag;
    logic [ERR_W-1:0]          magc;
    logic                      load_out;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mx_reg    <= 12'd500;
            corr_reg  <= 1'b0;
            nr_reg    <= 13'd1200;
            fr_reg    <= 14'd3600;
            tl_reg    <= 12'd524;
            stale_reg <= 8'd3;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_MAX_FWD:  mx_reg    <= pwdata[11:0];
                ADDR_CORRIDOR: corr_reg  <= pwdata[0];
                ADDR_NEAR:     nr_reg    <= pwdata[12:0];
                ADDR_FAR:      fr_reg    <= pwdata[13:0];
                ADDR_TURN:     tl_reg    <= pwdata[11:0];
                ADDR_STALE:    stale_reg <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_MAX_FWD:  prdata = DATA_W'(mx_reg);
            ADDR_CORRIDOR: prdata = DATA_W'(corr_reg);
            ADDR_NEAR:     prdata = DATA_W'(nr_reg);
            ADDR_FAR:      prdata = DATA_W'(fr_reg);
            ADDR_TURN:     prdata = DATA_W'(tl_reg);
            ADDR_STALE:    prdata = DATA_W'(stale_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        hd_wrapped = wrap_pi((ANG_W + 1)'(robot_heading));
        ahead18    = 18'(ahead_reg);
        nr18       = signed'({5'd0, nr_reg});
        fr18       = signed'({4'd0, fr_reg});
        stop       = (age_reg > stale_reg) || (ahead_reg < MIN_AHEAD);
        band       = (ahead18 > nr18) && (ahead18 < fr18);
        rev        = ((ahead18 <<< 1) < nr18) && (mx_reg[11:2] != 10'd0);
        diff       = 18'(ahead18 - nr18);
        num        = NUM_W'({15'd0, mx_reg} * {13'd0, diff[13:0]}) << 1;
        den        = DEN_W'(fr_reg - {1'b0, nr_reg});
        tl_prod    = tl_reg * DIV10_MUL;
        div_start  = (state_reg == ST_EVAL) && en_reg && !stop && band;
        cor_start  = (state_reg == ST_EVAL) && en_reg && !stop && !rev && !corr_reg;
    end

    pfvc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .busy  (div_busy),
        .quo   (quo)
    );

    pfvc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .ahead (ahead_reg),
        .side  (side_reg),
        .busy  (cor_busy),
        .angle (cor_angle)
    );

    always_comb
    begin
        step_s = signed'({4'd0, step_reg});
        if (corr_reg)
        begin
            if (pv_reg)
                err = ERR_W'(wrap_pi((ANG_W + 1)'(held_reg) - (ANG_W + 1)'(hd_reg)));
            else if (herr_reg > 0)
                err = herr_reg - step_s;
            else if (herr_reg < 0)
                err = herr_reg + step_s;
            else
                err = herr_reg;
        end
        else
        begin
            err = ERR_W'(cor_angle);
        end
        mag  = herr_reg[ERR_W-1] ? ERR_W'(-herr_reg) : ERR_W'(herr_reg);
        magc = (mag > {4'd0, tl_reg}) ? {4'd0, tl_reg} : mag;
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            herr_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (!en_reg)
                    begin
                        held_valid_reg <= 1'b0;
                        herr_reg       <= '0;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        if (corr_reg && pv_reg && !held_valid_reg)
                        begin
                            held_reg       <= round_quad(hd_reg);
                            held_valid_reg <= 1'b1;
                        end
                        if (stop || rev)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (!div_busy && !cor_busy)
                        state_reg <= ST_STEER;
                end
                ST_STEER:
                begin
                    herr_reg  <= err;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            en_reg    <= enabled;
            ahead_reg <= target_ahead;
            side_reg  <= target_side;
            age_reg   <= sighting_age;
            pv_reg    <= pose_valid;
            hd_reg    <= hd_wrapped;
        end
        if (state_reg == ST_EVAL)
        begin
            band_reg <= band;
            step_reg <= tl_prod[16 +: 12];
            turn_reg <= '0;
            if (en_reg && !stop && rev)
                fwd_reg <= -signed'({3'd0, mx_reg[11:2]});
            else
                fwd_reg <= '0;
        end
        if (state_reg == ST_STEER && band_reg)
            fwd_reg <= (quo > NUM_W'(mx_reg)) ? signed'({1'b0, mx_reg})
                                              : signed'({1'b0, quo[11:0]});
        if (state_reg == ST_CLAMP)
        begin
            if (mag >= SLOW_ERR)
                fwd_reg <= signed'({3'd0, mx_reg[11:2]});
            if (magc < DEADBAND)
                turn_reg <= '0;
            else if (herr_reg > 0)
                turn_reg <= signed'(magc[SPEED_W-1:0]);
            else
                turn_reg <= -signed'(magc[SPEED_W-1:0]);
        end
        if (load_out)
        begin
            out_fwd_reg  <= fwd_reg;
            out_turn_reg <= turn_reg;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign forward_speed = out_fwd_reg;
    assign turn_speed    = out_turn_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfvc_checker.sv
// ----------------------------------------------------------------------------
// pfvc_checker
// Port-level checks of the person-follow velocity controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfvc_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [pfvc_pkg::SPEED_W-1:0]  forward_speed,
    input wire logic signed [pfvc_pkg::SPEED_W-1:0]  turn_speed
);

    `PFVC_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accept did not block input")
    `PFVC_ASSERT_ALWAYS(a_out_from_work, $rose(out_valid) |-> $past(in_stall), "result without a request in work")
    `PFVC_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(forward_speed) && $stable(turn_speed)), "stalled result changed")
    `PFVC_ASSERT(a_deadband, (out_valid && turn_speed != 0) |-> (turn_speed >= 10 || turn_speed <= -10), "turn inside deadband")

endmodule

bind person_follow_velocity_controller pfvc_checker u_pfvc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .forward_speed (forward_speed),
    .turn_speed    (turn_speed)
);

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// person_follow_velocity_controller testbench
// Drives control ticks through the input channel with random gaps, stalls
// the output channel at random, and compares every speed command with a
// predictor of the follow controller. It runs under several register
// settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic signed [12:0] fwd;
    logic signed [12:0] turn;
} speed_cmd_t;

class speed_scoreboard;
    int max_fwd, corridor, near_mm, far_mm, turn_lim, stale_lim;
    int head_err, held_head;
    bit held_valid;
    speed_cmd_t pending[$];
    int errors;
    longint atan_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    function void clear_state();
        max_fwd = 500; corridor = 0; near_mm = 1200; far_mm = 3600;
        turn_lim = 524; stale_lim = 3;
        head_err = 0; held_head = 0; held_valid = 0;
        errors = 0;
    endfunction

    function int wrap_angle(int a);
        while (a > 3142) a -= 6283;
        while (a <= -3142) a += 6283;
        return a;
    endfunction

    function int bearing_mrad(int ahead, int side);
        longint x, y, z, xs, ys, mag, r;
        x = longint'(ahead) * 4096;
        y = longint'(side) * 4096;
        z = 0;
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_tab[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        mag = z < 0 ? -z : z;
        r = (mag * 1000 + (longint'(1) << 19)) >>> 20;
        return int'(z < 0 ? -r : r);
    endfunction

    function void note_request(bit en, int ahead, int side, int age, bit pv, int hd_raw);
        speed_cmd_t cmd;
        int hd, fwd, turn, err, mag, sgn;
        longint v;
        hd = wrap_angle(hd_raw);
        fwd = 0;
        turn = 0;
        if (!en)
        begin
            held_valid = 0;
            head_err = 0;
        end
        else
        begin
            if (corridor != 0 && pv && !held_valid)
            begin
                if (hd >= -785 && hd <= 785) held_head = 0;
                else if (hd > 785 && hd <= 2356) held_head = 1571;
                else if (hd >= -2356 && hd < -785) held_head = -1571;
                else held_head = 3142;
                held_valid = 1;
            end
            if (!(age > stale_lim || ahead < 10))
            begin
                if (ahead > near_mm && ahead < far_mm)
                begin
                    v = (longint'(max_fwd) * 2 * (ahead - near_mm)) / (far_mm - near_mm);
                    fwd = v > max_fwd ? max_fwd : int'(v);
                end
                else if (2 * ahead < near_mm)
                    fwd = -(max_fwd / 4);
                if (fwd >= 0)
                begin
                    err = head_err;
                    if (corridor != 0)
                    begin
                        if (pv)
                            err = wrap_angle(held_head - hd);
                        else if (err > 0)
                            err -= turn_lim / 10;
                        else if (err < 0)
                            err += turn_lim / 10;
                    end
                    else
                        err = bearing_mrad(ahead, side);
                    head_err = err;
                    sgn = err > 0 ? 1 : -1;
                    mag = err < 0 ? -err : err;
                    if (mag >= 524)
                        fwd = max_fwd / 4;
                    if (mag > turn_lim)
                        mag = turn_lim;
                    turn = sgn * mag;
                    if (turn > -10 && turn < 10)
                        turn = 0;
                end
            end
        end
        cmd.fwd = fwd[12:0];
        cmd.turn = turn[12:0];
        pending.push_back(cmd);
    endfunction

    function void check_result(logic signed [12:0] fwd, logic signed [12:0] turn);
        speed_cmd_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected command fwd=%0d turn=%0d", $time, fwd, turn);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (fwd !== want.fwd)
        begin
            $display("%0t: forward_speed expected %0d actual %0d", $time, want.fwd, fwd);
            errors++;
        end
        if (turn !== want.turn)
        begin
            $display("%0t: turn_speed expected %0d actual %0d", $time, want.turn, turn);
            errors++;
        end
    endfunction
endclass

module testbench;
    import pfvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, out_valid, out_stall;
    logic enabled, pose_valid;
    logic signed [AHEAD_W-1:0] target_ahead, target_side;
    logic [7:0] sighting_age;
    logic signed [HEAD_W-1:0] robot_heading;
    logic signed [SPEED_W-1:0] forward_speed, turn_speed;

    speed_scoreboard sb;
    int cycles;
    bit calm;

    person_follow_velocity_controller DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .enabled(enabled),
        .target_ahead(target_ahead), .target_side(target_side),
        .sighting_age(sighting_age), .pose_valid(pose_valid),
        .robot_heading(robot_heading), .out_valid(out_valid), .out_stall(out_stall),
        .forward_speed(forward_speed), .turn_speed(turn_speed)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("person_follow_velocity_controller verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(forward_speed, turn_speed);

    // random receiver stalls, with calm stretches
    initial
    begin
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            k = calm ? 0 : $urandom_range(0, 6);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input int idx, input int value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * idx); pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            0: sb.max_fwd = value;
            1: sb.corridor = value;
            2: sb.near_mm = value;
            3: sb.far_mm = value;
            4: sb.turn_lim = value;
            default: sb.stale_lim = value;
        endcase
    endtask

    task automatic set_regs(input int mx, input int cor, input int nr, input int fr,
                            input int tl, input int st);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        write_reg(0, mx); write_reg(1, cor); write_reg(2, nr);
        write_reg(3, fr); write_reg(4, tl); write_reg(5, st);
    endtask

    task automatic send_tick(input bit en, input int ahead, input int side,
                             input int age, input bit pv, input int hd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        enabled <= en; target_ahead <= ahead[15:0]; target_side <= side[15:0];
        sighting_age <= age[7:0]; pose_valid <= pv; robot_heading <= hd[12:0];
        do @(posedge clk); while (in_stall);
        sb.note_request(en, int'($signed(ahead[15:0])), int'($signed(side[15:0])),
                        age & 255, pv, int'($signed(hd[12:0])));
    endtask

    task automatic send_random(input int count);
        int ahead, side, age, hd;
        bit en, pv;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            en = ($urandom_range(0, 9) != 0);
            pv = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: ahead = $signed(16'($urandom));
                1: ahead = $urandom_range(0, 20);
                default: ahead = $urandom_range(0, 18000);
            endcase
            case ($urandom_range(0, 3))
                0: side = $signed(16'($urandom));
                default: side = int'($urandom_range(0, 12000)) - 6000;
            endcase
            if ($urandom_range(0, 7) == 0)
                age = $urandom_range(0, 255);
            else
                age = $urandom_range(0, sb.stale_lim + 1);
            if ($urandom_range(0, 5) == 0)
                hd = $signed(13'($urandom));
            else
                hd = int'($urandom_range(0, 6284)) - 3142;
            send_tick(en, ahead, side, age, pv, hd);
        end
        in_valid <= 1'b0;
        calm = 0;
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; enabled = 0; target_ahead = '0; target_side = '0;
        sighting_age = '0; pose_valid = 0; robot_heading = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(1, 2000, 0, 0, 1, 0);
        send_tick(1, 32767, 32767, 0, 1, 0);
        send_tick(1, 32767, -32768, 0, 1, 0);
        send_tick(1, -32768, 100, 0, 1, 0);
        send_tick(1, 9, 0, 0, 1, 0);
        send_tick(1, 10, 0, 0, 1, 0);
        send_tick(1, 1500, 3000, 0, 1, 0);
        send_tick(1, 1500, 8, 0, 1, 0);
        send_tick(1, 2000, 0, 4, 1, 0);
        send_tick(1, 2000, 0, 255, 1, 0);
        send_tick(1, 500, 100, 3, 1, 0);
        send_tick(1, 1200, 100, 0, 1, 0);
        send_tick(1, 3600, -100, 0, 1, 0);
        send_tick(0, 2000, 500, 0, 1, 0);
        in_valid <= 1'b0;

        set_regs(4000, 1, 1000, 16000, 3142, 255);
        send_tick(1, 2000, 0, 0, 1, 4095);
        send_tick(1, 2000, 0, 0, 1, 0);
        send_tick(1, 2000, 0, 0, 0, 0);
        send_tick(1, 2000, 0, 0, 0, 0);
        send_tick(0, 2000, 0, 0, 1, 786);
        send_tick(1, 2000, 0, 0, 1, 786);
        send_tick(1, 2000, 0, 0, 1, -4096);
        send_tick(0, 2000, 0, 0, 1, 0);
        send_tick(1, 5, 0, 0, 1, -2357);
        send_tick(1, 2000, 0, 0, 1, -785);
        send_tick(0, 2000, 0, 0, 1, 0);
        send_tick(1, 2000, 0, 0, 1, 2356);
        send_tick(1, 2000, 0, 0, 1, -3142);
        in_valid <= 1'b0;

        send_random(90);
        set_regs(500, 0, 1200, 3600, 524, 3);
        send_random(90);
        set_regs(0, 0, 0, 0, 0, 0);
        send_random(50);
        set_regs(4000, 1, 8000, 16000, 3142, 255);
        send_random(90);
        set_regs(2000, 1, 600, 2400, 1000, 10);
        send_random(90);
        set_regs(1500, 0, 8000, 1000, 3142, 255);
        send_random(90);

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("person_follow_velocity_controller verification clean");
        else
            $display("person_follow_velocity_controller verification failed");
        $finish;
    end
endmodule

`default_nettype wire
